@@ src/satl_pkg.sv @@
// ----------------------------------------------------------------------------
// satl_pkg
// Shared constants and types for the set-associative tag lookup block.
// ----------------------------------------------------------------------------
package satl_pkg;

  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 32;
  localparam int ADDR_WIDTH  = 32;

  localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
  localparam int SET_BITS    = $clog2(SETS);
  localparam int TAG_BITS    = ADDR_WIDTH - OFFSET_BITS - SET_BITS;
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_BITS    = WAY_BITS;
  localparam int WAY_OUT_BITS = 2;
  localparam int COUNT_BITS  = 32;

  localparam logic [AGE_BITS-1:0] AGE_TOP = AGE_BITS'(WAYS - 1);

  typedef logic [SET_BITS-1:0] set_idx_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [WAY_BITS-1:0] way_idx_t;

  typedef struct packed {
    logic                valid;
    tag_t                tag;
    logic [AGE_BITS-1:0] age;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] set_row_t;

  // Write port of the set store.
  typedef struct packed {
    logic     en;
    set_idx_t set;
    set_row_t row;
  } store_wr_t;

  // Outcome of one lookup.
  typedef struct packed {
    logic     hit;
    logic     filled;
    way_idx_t way;
  } lookup_res_t;

endpackage

@@ src/satl_in_if.sv @@
// ----------------------------------------------------------------------------
// satl_in_if
// Access channel: one byte address per transfer.
// ----------------------------------------------------------------------------
interface satl_in_if;
  logic                             valid;
  logic                             ready;
  logic [satl_pkg::ADDR_WIDTH-1:0]  addr;

  modport source (output valid, output addr, input ready);
  modport sink (input valid, input addr, output ready);
endinterface

@@ src/satl_out_if.sv @@
// ----------------------------------------------------------------------------
// satl_out_if
// Result channel: hit/fill outcome and running counts per transfer.
// ----------------------------------------------------------------------------
interface satl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  logic                                 filled;
  logic [satl_pkg::WAY_OUT_BITS-1:0]    way_used;
  logic [satl_pkg::COUNT_BITS-1:0]      hit_total;
  logic [satl_pkg::COUNT_BITS-1:0]      access_total;

  modport source (output valid, output hit, output filled, output way_used,
                  output hit_total, output access_total, input ready);
  modport sink (input valid, input hit, input filled, input way_used,
                input hit_total, input access_total, output ready);
endinterface

@@ src/satl_store.sv @@
// ----------------------------------------------------------------------------
// satl_store
// Set store: one row of all ways per set, synchronous read registered on
// rd_en. Per-row valid flops make unwritten rows read as all zero.
// ----------------------------------------------------------------------------
module satl_store (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  satl_pkg::set_idx_t    rd_set,
  output satl_pkg::set_row_t    rd_row,
  input  satl_pkg::store_wr_t   wr
);

  satl_pkg::set_row_t       mem [satl_pkg::SETS];
  logic [satl_pkg::SETS-1:0] row_written;
  satl_pkg::set_row_t       rd_data;
  logic                     rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.set] <= wr.row;
    end
    if (rd_en) begin
      rd_data <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
      rd_written  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_written[wr.set] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= row_written[rd_set];
      end
    end
  end

  assign rd_row = rd_written ? rd_data : '0;

endmodule

@@ src/satl_update.sv @@
// ----------------------------------------------------------------------------
// satl_update
// Tag compare and age update for one set: lookup pass, then fill pass on a
// miss.
// ----------------------------------------------------------------------------
module satl_update (
  input  satl_pkg::set_row_t    row,
  input  satl_pkg::tag_t        tag,
  output satl_pkg::set_row_t    new_row,
  output satl_pkg::lookup_res_t res
);

  always_comb begin
    logic                 hit_found;
    logic                 fill_found;
    satl_pkg::way_idx_t   hit_way;
    satl_pkg::way_idx_t   fill_way;
    satl_pkg::set_row_t   pass1;
    satl_pkg::set_row_t   pass2;

    hit_found  = 1'b0;
    fill_found = 1'b0;
    hit_way    = '0;
    fill_way   = '0;
    pass1      = row;

    // Lookup pass: first matching valid way takes the top age.
    for (int w = 0; w < satl_pkg::WAYS; w++) begin
      if (!hit_found && row[w].valid && row[w].tag == tag) begin
        hit_found    = 1'b1;
        hit_way      = satl_pkg::WAY_BITS'(w);
        pass1[w].age = satl_pkg::AGE_TOP;
      end else if (row[w].age != '0) begin
        pass1[w].age = row[w].age - 1'b1;
      end
    end

    // Fill pass on a miss: the lowest way whose age reached zero is taken.
    pass2 = pass1;
    if (!hit_found) begin
      for (int w = 0; w < satl_pkg::WAYS; w++) begin
        if (!fill_found && pass1[w].age == '0) begin
          fill_found     = 1'b1;
          fill_way       = satl_pkg::WAY_BITS'(w);
          pass2[w].age   = satl_pkg::AGE_TOP;
          pass2[w].valid = 1'b1;
          pass2[w].tag   = tag;
        end else if (pass1[w].age != '0) begin
          pass2[w].age = pass1[w].age - 1'b1;
        end
      end
    end

    new_row    = pass2;
    res.hit    = hit_found;
    res.filled = fill_found;
    res.way    = hit_found ? hit_way : (fill_found ? fill_way : '0);
  end

endmodule

@@ src/set_assoc_cache_tag_lookup.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Splits each address into set and tag, looks the tag up across all ways of
// the set, updates ages and fills on a miss, and counts hits and accesses.
// ----------------------------------------------------------------------------
// Pipeline: an accepted address is held in s1 while its set row is read; the
// result is registered when s1 fires. Throughput: one access per cycle while
// rsp is not stalled; the row is read at the address transfer, written back
// when s1 fires and forwarded when back-to-back accesses hit the same set.
// Reset: rst clears the pipeline, both counters and the per-set written
// flags, so every set reads as empty right after reset with no clearing pass.
module set_assoc_cache_tag_lookup (
  input  logic          clk,
  input  logic          rst,
  satl_in_if.sink       req,
  satl_out_if.source    rsp
);

  logic                  s1_valid;
  logic                  s1_fire;
  logic                  accept;
  satl_pkg::set_idx_t    s1_set;
  satl_pkg::tag_t        s1_tag;
  satl_pkg::set_idx_t    req_set;
  satl_pkg::tag_t        req_tag;
  logic                  fwd;
  satl_pkg::set_row_t    fwd_row;
  satl_pkg::set_row_t    rd_row;
  satl_pkg::set_row_t    cur_row;
  satl_pkg::set_row_t    new_row;
  satl_pkg::lookup_res_t res;
  satl_pkg::store_wr_t   wr;
  logic                  out_valid;
  logic                  out_hit;
  logic                  out_filled;
  logic [satl_pkg::WAY_OUT_BITS-1:0] out_way;
  logic [satl_pkg::COUNT_BITS-1:0]   hit_count;
  logic [satl_pkg::COUNT_BITS-1:0]   access_count;

  assign req_set = req.addr[satl_pkg::OFFSET_BITS +: satl_pkg::SET_BITS];
  assign req_tag = req.addr[satl_pkg::OFFSET_BITS + satl_pkg::SET_BITS +: satl_pkg::TAG_BITS];

  assign s1_fire   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;
  assign accept    = req.valid && req.ready;

  satl_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_set (req_set),
    .rd_row (rd_row),
    .wr     (wr)
  );

  // The store returns the old row when it is written in the same cycle as it
  // is read, so that write is carried along here.
  assign cur_row = fwd ? fwd_row : rd_row;

  satl_update u_update (
    .row     (cur_row),
    .tag     (s1_tag),
    .new_row (new_row),
    .res     (res)
  );

  assign wr.en  = s1_fire;
  assign wr.set = s1_set;
  assign wr.row = new_row;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_set  <= req_set;
      s1_tag  <= req_tag;
      fwd_row <= new_row;
    end
    if (s1_fire) begin
      out_hit    <= res.hit;
      out_filled <= res.filled;
      out_way    <= satl_pkg::WAY_OUT_BITS'(res.way);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      fwd          <= 1'b0;
      out_valid    <= 1'b0;
      hit_count    <= '0;
      access_count <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd      <= s1_fire && (s1_set == req_set);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid    <= 1'b1;
        access_count <= access_count + 1'b1;
        if (res.hit) begin
          hit_count <= hit_count + 1'b1;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.filled       = out_filled;
  assign rsp.way_used     = out_way;
  assign rsp.hit_total    = hit_count;
  assign rsp.access_total = access_count;

  a_fire_shows_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("lookup finished without a pending result");

  a_access_count_step: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> access_count == $past(access_count) + 1'b1)
    else $error("access count did not advance by one per lookup");

  a_hit_excludes_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_filled))
    else $error("result reports both hit and fill");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && out_valid && !rsp.ready)
    else $error("access channel stalled without a blocked lookup");

endmodule
